@@ sv/sha384_pkg.sv @@
// SHA-384 package: round constants, initial hash values, state codes.
// No dependencies.
`default_nettype none
package sha384_pkg;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ROUND = 6'b000010,
        ST_ADD   = 6'b000100,
        ST_PAD   = 6'b001000,
        ST_LEN   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    localparam logic [63:0] C_IV [8] = '{
        64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17,
        64'h152FECD8F70E5939, 64'h67332667FFC00B31, 64'h8EB44A8768581511,
        64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
    };

    localparam logic [63:0] C_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [6:0] C_LAST_ROUND = 7'd79;
    localparam logic [6:0] C_PAD_LIMIT  = 7'd111;
    localparam logic [2:0] C_LAST_WORD  = 3'd5;

endpackage
`default_nettype wire

@@ sv/sha384_hash_engine_core.sv @@
// SHA-384 streaming hasher top level: byte packing, padding, round unit.
// Depends on sha384_pkg.
// A byte that completes no block is simply packed; a full block runs 80 rounds on the
// one shared round unit, then the chaining add, before the next byte is accepted.
// A last byte adds padding and one or two further compressions (one more before them
// when its byte fills a block), then six output words.
// Input: bytes are accepted only while idle, not during rounds, padding or output.
// Reset: synchronous active low; chaining to SHA-384 IV, count cleared, idle.
`default_nettype none
module sha384_hash_engine_core
    import sha384_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,  // [7:0] msg_byte, [8] has_byte, pad
    input  wire logic        i_s_axis_tlast,  // last
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,  // [63:0] digest_word, [66:64] word_index, pad
    output logic             o_m_axis_tlast   // last_word
);

    t_state       r_state;
    logic [63:0]  r_h [8];
    logic [63:0]  r_v [8];
    logic [63:0]  r_w [16];
    logic [127:0] r_cnt;
    logic [6:0]   r_rnd;
    logic         r_fin;     // pending final block after this compression
    logic         r_two;     // length block still to build
    logic [2:0]   r_oidx;

    wire s_acc = i_s_axis_tvalid && o_s_axis_tready;
    wire m_acc = o_m_axis_tvalid && i_m_axis_tready;
    wire [7:0] w_byte = i_s_axis_tdata[7:0];
    wire       w_has  = i_s_axis_tdata[8];
    wire [6:0] w_pos  = r_cnt[6:0];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tdata  = {5'd0, r_oidx, r_h[r_oidx]};
    assign o_m_axis_tlast  = (r_oidx == C_LAST_WORD);

    // round unit
    logic [3:0]  w_t;
    logic [63:0] w_x2, w_x15, w_sig0, w_sig1, w_wt, w_s1, w_ch, w_t1, w_s0, w_maj;
    always_comb begin
        w_t    = r_rnd[3:0];
        w_x2   = r_w[w_t - 4'd2];
        w_x15  = r_w[w_t - 4'd15];
        w_sig1 = {w_x2[18:0], w_x2[63:19]} ^ {w_x2[60:0], w_x2[63:61]} ^ (w_x2 >> 6);
        w_sig0 = {w_x15[0], w_x15[63:1]} ^ {w_x15[7:0], w_x15[63:8]} ^ (w_x15 >> 7);
        w_wt   = (r_rnd >= 7'd16) ? r_w[w_t] + w_sig1 + r_w[w_t - 4'd7] + w_sig0 : r_w[w_t];
        w_s1   = {r_v[4][13:0], r_v[4][63:14]} ^ {r_v[4][17:0], r_v[4][63:18]}
               ^ {r_v[4][40:0], r_v[4][63:41]};
        w_ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_t1   = r_v[7] + w_s1 + w_ch + C_K[r_rnd] + w_wt;
        w_s0   = {r_v[0][27:0], r_v[0][63:28]} ^ {r_v[0][33:0], r_v[0][63:34]}
               ^ {r_v[0][38:0], r_v[0][63:39]};
        w_maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    end

    logic [5:0]  w_sh;
    logic [63:0] w_keep;
    always_comb begin
        w_sh   = 6'd56 - {w_pos[2:0], 3'd0};
        w_keep = (w_pos[2:0] == 3'd0) ? 64'd0 : (~64'd0 << ({1'b0, w_sh} + 7'd8));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= C_IV[i];
                r_v[i] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_fin <= i_s_axis_tlast;
                        if (w_has) begin
                            if (w_pos[2:0] == 3'd0)
                                r_w[w_pos[6:3]] <= {56'd0, w_byte} << w_sh;
                            else
                                r_w[w_pos[6:3]] <= r_w[w_pos[6:3]] | ({56'd0, w_byte} << w_sh);
                            r_cnt <= r_cnt + 128'd1;
                            if (w_pos == 7'h7F) begin
                                r_state <= ST_ROUND;
                                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                            end else if (i_s_axis_tlast) begin
                                r_state <= ST_PAD;
                            end
                        end else if (i_s_axis_tlast) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_ROUND: begin
                    r_w[w_t] <= w_wt;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_s0 + w_maj;
                    r_rnd  <= (r_rnd == C_LAST_ROUND) ? 7'd0 : r_rnd + 7'd1;
                    if (r_rnd == C_LAST_ROUND) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    priority if (r_two) begin
                        r_two   <= 1'b0;
                        r_state <= ST_LEN;
                    end else if (r_fin) begin
                        // length block done: output, else pad the final block
                        if (r_oidx == 3'd7) begin
                            r_oidx  <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_PAD;
                        end
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_PAD: begin
                    r_w[w_pos[6:3]] <= (r_w[w_pos[6:3]] & w_keep) | (64'h80 << w_sh);
                    for (int i = 0; i < 16; i++)
                        if (4'(i) > w_pos[6:3]) r_w[i] <= '0;
                    if (w_pos > C_PAD_LIMIT) begin
                        r_two   <= 1'b1;
                        r_state <= ST_ROUND;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    end else begin
                        r_state <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    if (r_two == 1'b0 && w_pos > C_PAD_LIMIT)
                        for (int i = 0; i < 14; i++) r_w[i] <= '0;
                    r_w[14] <= r_cnt[124:61];
                    r_w[15] <= {r_cnt[60:0], 3'd0};
                    r_oidx  <= 3'd7;
                    r_state <= ST_ROUND;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                ST_OUT: begin
                    if (m_acc) begin
                        if (r_oidx == C_LAST_WORD) begin
                            r_state <= ST_IDLE;
                            r_fin   <= 1'b0;
                            r_cnt   <= '0;
                            for (int i = 0; i < 8; i++) r_h[i] <= C_IV[i];
                            r_oidx  <= '0;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_rnd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND) |-> (r_rnd == 7'd0)) else $error("round counter stray");
    a_out_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid) |-> (r_oidx <= C_LAST_WORD)) else $error("bad word index");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && o_m_axis_tlast) |=> (r_cnt == '0 && r_state == ST_IDLE))
        else $error("no restart after digest");

endmodule
`default_nettype wire
